[sv/ctc_pkg.sv]
package ctc_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int CELL_COUNT    = SCREEN_WIDTH * SCREEN_HEIGHT;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CFG_IDX_W = 2;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_BLANK   = 8'd32;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] base;
        logic             scroll;
    } cursor_upd_t;

endpackage

[sv/ctc_cursor.sv]
module ctc_cursor
    import ctc_pkg::*;
(
    input  logic [ROW_W-1:0] cur_row,
    input  logic [COL_W-1:0] cur_col,
    input  logic [ROW_W-1:0] base,
    input  logic [7:0]       char_code,
    output cursor_upd_t      upd
);

    logic [COL_W:0] col_inc;
    logic           wrap;

    always_comb
    begin
        col_inc = {1'b0, cur_col} + (COL_W+1)'(1);
        wrap    = (char_code == CHAR_NEWLINE) || (col_inc >= (COL_W+1)'(SCREEN_WIDTH));
        upd.row    = cur_row;
        upd.col    = col_inc[COL_W-1:0];
        upd.base   = base;
        upd.scroll = 1'b0;
        if (wrap)
        begin
            upd.col = '0;
            if (cur_row == LAST_ROW)
            begin
                // rows are kept in a ring: scrolling just rotates the top row index
                upd.scroll = 1'b1;
                upd.base   = (base == LAST_ROW) ? '0 : base + ROW_W'(1);
            end
            else
            begin
                upd.row = cur_row + ROW_W'(1);
            end
        end
    end

endmodule

[sv/text_console_cursor_scroll_unit.sv]
// Put item: the start transfer is registered, S_EXEC writes the cell and done
// is registered from it; a new start is taken in the done cycle. Read item:
// S_EXEC reads the cell, S_RDWAIT registers it and done follows. A put that
// scrolls also blanks one row of the ring in S_BLANK before done. After reset the screen
// memory is swept at one cell per cycle (SCREEN_WIDTH*SCREEN_HEIGHT = 2000 cells) with busy high.
// done is a one-cycle strobe; the receiver cannot stall.
module text_console_cursor_scroll_unit
    import ctc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 command,
    input  logic [7:0]           char_code,
    input  logic [ROW_W-1:0]     read_row,
    input  logic [COL_W-1:0]     read_col,
    output logic                 done,
    output logic [7:0]           cell_char,
    output logic [7:0]           cell_attr,
    output logic [ROW_W-1:0]     cursor_row,
    output logic [COL_W-1:0]     cursor_col,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [3:0]           cfg_data
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] base_reg, base_next;
    logic [ROW_W-1:0] sweep_row_reg, sweep_row_next;
    logic [COL_W-1:0] sweep_col_reg, sweep_col_next;
    logic [3:0]       fg_reg, bg_reg;
    logic             done_reg, done_next;
    logic [7:0]       char_out_reg, char_out_next;
    logic [7:0]       attr_out_reg, attr_out_next;

    logic             cmd_reg;
    logic [7:0]       char_reg;
    logic [ROW_W-1:0] rrow_reg;
    logic [COL_W-1:0] rcol_reg;
    logic             rd_ok_reg;

    logic [15:0]      mem [CELL_COUNT];
    logic [15:0]      rd_data_reg;

    logic [ROW_W-1:0] log_row;
    logic [ROW_W:0]   ring_sum;
    logic [ROW_W-1:0] phys_row;
    logic [ROW_W-1:0] addr_row;
    logic [COL_W-1:0] addr_col;
    logic [ADDR_W-1:0] addr;
    logic             we, re;
    logic [15:0]      wdata;
    logic [7:0]       cur_attr;
    logic             accept;
    cursor_upd_t      upd;

    assign cur_attr  = {bg_reg, fg_reg};
    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    ctc_cursor u_cursor (
        .cur_row   (row_reg),
        .cur_col   (col_reg),
        .base      (base_reg),
        .char_code (char_reg),
        .upd       (upd)
    );

    // logical row to ring position, then row*width+col; one address unit for all accesses
    always_comb
    begin
        log_row  = (cmd_reg == CMD_READ) ? rrow_reg : row_reg;
        ring_sum = {1'b0, log_row} + {1'b0, base_reg};
        phys_row = (ring_sum >= (ROW_W+1)'(SCREEN_HEIGHT))
                 ? ROW_W'(ring_sum - (ROW_W+1)'(SCREEN_HEIGHT)) : ring_sum[ROW_W-1:0];
        if (state_reg == S_EXEC)
        begin
            addr_row = phys_row;
            addr_col = (cmd_reg == CMD_READ) ? rcol_reg : col_reg;
        end
        else
        begin
            addr_row = sweep_row_reg;
            addr_col = sweep_col_reg;
        end
        addr = ADDR_W'(addr_row) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(addr_col);
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        done_next      = 1'b0;
        char_out_next  = char_out_reg;
        attr_out_next  = attr_out_reg;
        we             = 1'b0;
        re             = 1'b0;
        wdata          = {cur_attr, CHAR_BLANK};
        case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                wdata = {RESET_ATTR, CHAR_BLANK};
                if (sweep_col_reg == LAST_COL)
                begin
                    sweep_col_next = '0;
                    sweep_row_next = sweep_row_reg + ROW_W'(1);
                    if (sweep_row_reg == LAST_ROW)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + COL_W'(1);
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_READ)
                begin
                    re         = rd_ok_reg;
                    state_next = S_RDWAIT;
                end
                else
                begin
                    we            = (char_reg != CHAR_NEWLINE);
                    wdata         = {cur_attr, char_reg};
                    row_next      = upd.row;
                    col_next      = upd.col;
                    base_next     = upd.base;
                    char_out_next = '0;
                    attr_out_next = '0;
                    if (upd.scroll)
                    begin
                        // old top row becomes the new bottom row
                        sweep_row_next = base_reg;
                        sweep_col_next = '0;
                        state_next     = S_BLANK;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RDWAIT:
            begin
                char_out_next = rd_ok_reg ? rd_data_reg[7:0] : 8'd0;
                attr_out_next = rd_ok_reg ? rd_data_reg[15:8] : 8'd0;
                done_next     = 1'b1;
                state_next    = S_IDLE;
            end
            S_BLANK:
            begin
                we = 1'b1;
                sweep_col_next = sweep_col_reg + COL_W'(1);
                if (sweep_col_reg == LAST_COL)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            fg_reg        <= RESET_ATTR[3:0];
            bg_reg        <= RESET_ATTR[7:4];
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            done_reg      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FG)
                begin
                    fg_reg <= cfg_data;
                end
                else if (cfg_index == CFG_BG)
                begin
                    bg_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_out_reg <= char_out_next;
        attr_out_reg <= attr_out_next;
        if (accept)
        begin
            cmd_reg   <= command;
            char_reg  <= char_code;
            rrow_reg  <= read_row;
            rcol_reg  <= read_col;
            rd_ok_reg <= ({1'b0, read_row} < (ROW_W+1)'(SCREEN_HEIGHT))
                      && ({1'b0, read_col} < (COL_W+1)'(SCREEN_WIDTH));
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign done       = done_reg;
    assign cell_char  = char_out_reg;
    assign cell_attr  = attr_out_reg;
    assign cursor_row = row_reg;
    assign cursor_col = col_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cursor_row} < (ROW_W+1)'(SCREEN_HEIGHT))
        && ({1'b0, cursor_col} < (COL_W+1)'(SCREEN_WIDTH)))
        else $error("cursor off screen");

    a_ring_base: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, base_reg} < (ROW_W+1)'(SCREEN_HEIGHT)))
        else $error("ring base out of range");

endmodule
